[src/fgl_pkg.sv]
// ----------------------------------------------------------------------------
// fgl_pkg
// shared widths, control types and register indexes of the fuzz voice
// ----------------------------------------------------------------------------
`default_nettype none

package fgl_pkg;

    localparam int MUL_W  = 33;
    localparam int ACC_W  = 2 * MUL_W;
    localparam int SH_W   = 5;
    localparam int DIV_NW = 62;
    localparam int DIV_DW = 38;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 24;

    typedef struct packed {
        logic            valid;
        logic            clr;
        logic            sub;
        logic [SH_W-1:0] sh;
    } mac_op_t;

    localparam logic [CFG_AW-1:0] CFG_DRIVE_GAIN   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_DRIVE_OFFSET = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_GATE_AMOUNT  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_OUT_GAIN     = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_BYPASS       = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_LOWPASS_B0   = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_LOWPASS_A1   = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_LOWPASS_A2   = 3'd7;

endpackage

`default_nettype wire

[src/fgl_mac.sv]
// ----------------------------------------------------------------------------
// fgl_mac
// shared signed multiplier with registered product and shift accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module fgl_mac (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire fgl_pkg::mac_op_t                  op,
    input  wire logic signed [fgl_pkg::MUL_W-1:0]  a,
    input  wire logic signed [fgl_pkg::MUL_W-1:0]  b,
    output logic signed [fgl_pkg::ACC_W-1:0]       acc
);

    logic signed [fgl_pkg::ACC_W-1:0] prod_reg;
    logic signed [fgl_pkg::ACC_W-1:0] prod_next;
    fgl_pkg::mac_op_t                 ctl_reg;
    logic signed [fgl_pkg::ACC_W-1:0] acc_reg;
    logic signed [fgl_pkg::ACC_W-1:0] acc_next;
    logic signed [fgl_pkg::ACC_W-1:0] shifted;
    logic signed [fgl_pkg::ACC_W-1:0] base;

    assign prod_next = a * b;
    assign shifted   = prod_reg <<< ctl_reg.sh;
    assign base      = ctl_reg.clr ? '0 : acc_reg;
    assign acc_next  = ctl_reg.sub ? base - shifted : base + shifted;
    assign acc       = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= op;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (ctl_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

[src/fgl_div.sv]
// ----------------------------------------------------------------------------
// fgl_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fgl_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [fgl_pkg::DIV_NW-1:0]   dividend,
    input  wire logic [fgl_pkg::DIV_DW-1:0]   divisor,
    output logic                              done,
    output logic [fgl_pkg::DIV_NW-1:0]        quotient
);

    localparam int CNT_W = $clog2(fgl_pkg::DIV_NW + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [fgl_pkg::DIV_DW-1:0]  rem_reg;
    logic [fgl_pkg::DIV_DW-1:0]  dsr_reg;
    logic [fgl_pkg::DIV_NW-1:0]  quo_reg;
    logic [fgl_pkg::DIV_DW:0]    trial;
    logic                        fits;

    assign trial    = {rem_reg, quo_reg[fgl_pkg::DIV_NW-1]};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(fgl_pkg::DIV_NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= fgl_pkg::DIV_DW'(trial - {1'b0, dsr_reg});
            end else begin
                rem_reg <= trial[fgl_pkg::DIV_DW-1:0];
            end
            quo_reg <= {quo_reg[fgl_pkg::DIV_NW-2:0], fits};
        end
    end

endmodule

`default_nettype wire

[src/fuzz_gate_lowpass_voice.sv]
// ----------------------------------------------------------------------------
// fuzz_gate_lowpass_voice
// drive, pade tanh, envelope gate, biquad lowpass and output gain per channel;
// in bypass only the output gain is applied
//   channel   handshake           payload
//   s_        s_valid / s_ready   s_channel_index, s_sample_in
//   m_        m_valid / m_ready   m_channel_out, m_sample_out
//   cfg_      cfg_wr_en           cfg_index, cfg_wr_data
//
// one word at a time; the passes of the shared divider and the chain of
// dependent multiplies on the one shared multiplier set the time per word,
// which is longer when the gate divides and shortest in bypass
// synchronous active-low reset restores register defaults, zeroes envelopes
// and filter state
// a finished word waits in the output register; the next word is taken
// while it waits, and the block stalls only when a second word completes
// ----------------------------------------------------------------------------
`default_nettype none

module fuzz_gate_lowpass_voice #(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [fgl_pkg::CFG_AW-1:0]         cfg_index,
    input  wire logic [fgl_pkg::CFG_DW-1:0]         cfg_wr_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_channel_index,
    input  wire logic signed [SAMPLE_BITS-1:0]      s_sample_in,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_channel_out,
    output logic signed [SAMPLE_BITS-1:0]           m_sample_out
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ACC_W = fgl_pkg::ACC_W;
    localparam int MUL_W = fgl_pkg::MUL_W;

    localparam logic signed [ACC_W-1:0] DRV_LIM = ACC_W'(64'sd687194767360);
    localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] S32_MIN = -S32_MAX - ACC_W'(64'sd1);
    localparam logic signed [ACC_W-1:0] SMP_MAX =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SMP_MIN = -SMP_MAX - ACC_W'(64'sd1);
    localparam logic [24:0] N1_BASE  = 25'd24772608;
    localparam logic [30:0] N2_BASE  = 31'd1135411200;
    localparam logic [35:0] N3_BASE  = 36'd8856207360;
    localparam logic [27:0] D1_BASE  = 28'd206438400;
    localparam logic [33:0] D2_BASE  = 34'd4087480320;
    localparam logic [37:0] D3_BASE  = 38'd8856207360;
    localparam logic [21:0] THR_BASE = 22'd167772;
    localparam logic [21:0] THR_K    = 22'd2348810;
    localparam logic [15:0] REL_BASE = 16'd6554;
    localparam logic [22:0] Q_MAX    = 23'h7FFFFF;

    typedef enum logic [5:0] {
        ST_IDLE, ST_BYP_MUL,
        ST_DRV_OFF, ST_DRV_MUL, ST_DRV_W, ST_DRV_CAP,
        ST_SQ_MUL, ST_SQ_W, ST_SQ_CAP,
        ST_N1_MUL, ST_N1_W, ST_N1_CAP,
        ST_N2_MUL, ST_N2_W, ST_N2_CAP,
        ST_D1_MUL, ST_D1_W, ST_D1_CAP,
        ST_D2_LO, ST_D2_HI, ST_D2_W, ST_D2_CAP,
        ST_NUM_LO, ST_NUM_HI, ST_NUM_W, ST_NUM_DIV, ST_TANH_WAIT,
        ST_THR_MUL, ST_THR_W, ST_THR_CAP,
        ST_ENV_A, ST_ENV_B, ST_ENV_W, ST_ENV_CAP,
        ST_GATE, ST_GATE_W, ST_GATE_DIV, ST_GATE_WAIT,
        ST_F0, ST_F1, ST_F_W1, ST_Y_CAP,
        ST_F2, ST_F3, ST_F4, ST_F_W2, ST_S1_CAP,
        ST_F5, ST_F6, ST_F_W3, ST_S2_CAP,
        ST_OUT_MUL, ST_OUT_W, ST_RES
    } state_t;

    state_t state_reg;

    logic [23:0]        drive_gain_reg;
    logic signed [23:0] drive_offset_reg;
    logic [15:0]        gate_amount_reg;
    logic [19:0]        out_gain_reg;
    logic               bypass_reg;
    logic signed [23:0] b0_reg;
    logic signed [23:0] a1_reg;
    logic signed [23:0] a2_reg;

    logic [23:0]        env_mem [CHANNELS];
    logic signed [31:0] s1_mem  [CHANNELS];
    logic signed [31:0] s2_mem  [CHANNELS];

    logic                          chan_reg;
    logic [CH_W-1:0]               idx_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          neg_reg;
    logic [25:0]                   mag_reg;
    logic [20:0]                   u_reg;
    logic [24:0]                   n1_reg;
    logic [30:0]                   n2_reg;
    logic [35:0]                   n3_reg;
    logic [27:0]                   d1_reg;
    logic [33:0]                   d2_reg;
    logic [37:0]                   d3_reg;
    logic [21:0]                   thr_reg;
    logic [22:0]                   lvl_reg;
    logic [23:0]                   env_reg;
    logic signed [23:0]            fg_reg;
    logic signed [31:0]            y_reg;
    logic signed [31:0]            s1_reg;
    logic signed [31:0]            s2_reg;
    logic                          m_valid_reg;
    logic                          m_chan_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg;

    logic [CH_W-1:0]               in_idx;
    fgl_pkg::mac_op_t              mac_op;
    logic signed [MUL_W-1:0]       mul_a;
    logic signed [MUL_W-1:0]       mul_b;
    logic signed [ACC_W-1:0]       acc;
    logic                          div_start;
    logic [fgl_pkg::DIV_NW-1:0]    div_dividend;
    logic [fgl_pkg::DIV_DW-1:0]    div_divisor;
    logic                          div_done;
    logic [fgl_pkg::DIV_NW-1:0]    div_quo;

    logic signed [ACC_W-1:0]       drv_c;
    logic signed [ACC_W-1:0]       drv_t;
    logic [20:0]                   sq_u;
    logic [15:0]                   rel;
    logic [16:0]                   orel;
    logic [22:0]                   q_sat;
    logic [22:0]                   gq;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > S32_MAX) begin
            return 32'sh7FFFFFFF;
        end else if (v < S32_MIN) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
        input logic signed [ACC_W-1:0] v
    );
        if (v > SMP_MAX) begin
            return SAMPLE_BITS'(SMP_MAX);
        end else if (v < SMP_MIN) begin
            return SAMPLE_BITS'(SMP_MIN);
        end
        return SAMPLE_BITS'(v);
    endfunction

    assign in_idx = (CHANNELS > 1) ? CH_W'(s_channel_index) : '0;

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_chan_reg;
    assign m_sample_out  = m_sample_reg;

    assign drv_c = (acc > DRV_LIM) ? DRV_LIM : ((acc < -DRV_LIM) ? -DRV_LIM : acc);
    assign drv_t = drv_c >>> 14;
    assign sq_u  = 21'(acc >>> 30);
    assign rel   = REL_BASE + {1'b0, gate_amount_reg[15:1]};
    assign orel  = 17'h10000 - 17'(rel);
    assign q_sat = (div_quo > fgl_pkg::DIV_NW'(Q_MAX)) ? Q_MAX : 23'(div_quo);
    assign gq    = 23'(div_quo);

    fgl_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (mac_op),
        .a       (mul_a),
        .b       (mul_b),
        .acc     (acc)
    );

    fgl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // operand select for the shared multiplier and start and operands of the divider
    always_comb begin
        mac_op       = '0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = fgl_pkg::DIV_NW'(acc);
        div_divisor  = (state_reg == ST_GATE_DIV) ? fgl_pkg::DIV_DW'(thr_reg) : d3_reg;
        unique case (state_reg)
            ST_BYP_MUL, ST_OUT_MUL: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, sh: '0};
                mul_a  = (state_reg == ST_BYP_MUL) ? MUL_W'(x_reg) : MUL_W'(y_reg);
                mul_b  = $signed(MUL_W'(out_gain_reg));
            end
            ST_DRV_OFF: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, sh: 5'd19};
                mul_a  = MUL_W'(drive_offset_reg);
                mul_b  = MUL_W'(1);
            end
            ST_DRV_MUL: begin
                mac_op = '{valid: 1'b1, clr: 1'b0, sub: 1'b0, sh: '0};
                mul_a  = MUL_W'(x_reg);
                mul_b  = $signed(MUL_W'(drive_gain_reg));
            end
            ST_SQ_MUL: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, sh: '0};
                mul_a  = $signed(MUL_W'(mag_reg));
                mul_b  = $signed(MUL_W'(mag_reg));
            end
            ST_N1_MUL, ST_N2_MUL, ST_D1_MUL: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, sh: '0};
                mul_a  = $signed(MUL_W'(u_reg));
                mul_b  = (state_reg == ST_N1_MUL) ? $signed(MUL_W'(n1_reg)) :
                         (state_reg == ST_N2_MUL) ? $signed(MUL_W'(n2_reg)) :
                                                    $signed(MUL_W'(d1_reg));
            end
            ST_D2_LO: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, sh: '0};
                mul_a  = $signed(MUL_W'(u_reg));
                mul_b  = $signed(MUL_W'(d2_reg[17:0]));
            end
            ST_D2_HI: begin
                mac_op = '{valid: 1'b1, clr: 1'b0, sub: 1'b0, sh: 5'd18};
                mul_a  = $signed(MUL_W'(u_reg));
                mul_b  = $signed(MUL_W'(d2_reg[33:18]));
            end
            ST_NUM_LO: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, sh: '0};
                mul_a  = $signed(MUL_W'(mag_reg));
                mul_b  = $signed(MUL_W'(n3_reg[17:0]));
            end
            ST_NUM_HI: begin
                mac_op = '{valid: 1'b1, clr: 1'b0, sub: 1'b0, sh: 5'd18};
                mul_a  = $signed(MUL_W'(mag_reg));
                mul_b  = $signed(MUL_W'(n3_reg[35:18]));
            end
            ST_NUM_DIV, ST_GATE_DIV: begin
                div_start = 1'b1;
            end
            ST_THR_MUL: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, sh: '0};
                mul_a  = $signed(MUL_W'(gate_amount_reg));
                mul_b  = $signed(MUL_W'(THR_K));
            end
            ST_ENV_A: begin
                if (!(24'(lvl_reg) > env_reg)) begin
                    mac_op = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, sh: '0};
                end
                mul_a = $signed(MUL_W'(env_reg));
                mul_b = $signed(MUL_W'(rel));
            end
            ST_ENV_B: begin
                mac_op = '{valid: 1'b1, clr: 1'b0, sub: 1'b0, sh: '0};
                mul_a  = $signed(MUL_W'(lvl_reg));
                mul_b  = $signed(MUL_W'(orel));
            end
            ST_GATE: begin
                if (env_reg < 24'(thr_reg)) begin
                    mac_op = '{valid: 1'b1, clr: 1'b1, sub: 1'b0, sh: '0};
                end
                mul_a = $signed(MUL_W'(lvl_reg));
                mul_b = $signed(MUL_W'(env_reg));
            end
            ST_F0, ST_F2, ST_F5: begin
                mac_op = '{valid: 1'b1, clr: 1'b1, sub: 1'b0,
                           sh: (state_reg == ST_F2) ? 5'd1 : 5'd0};
                mul_a  = MUL_W'(b0_reg);
                mul_b  = MUL_W'(fg_reg);
            end
            ST_F1, ST_F3: begin
                mac_op = '{valid: 1'b1, clr: 1'b0, sub: 1'b0, sh: 5'd22};
                mul_a  = (state_reg == ST_F1) ? MUL_W'(s1_reg) : MUL_W'(s2_reg);
                mul_b  = MUL_W'(1);
            end
            ST_F4, ST_F6: begin
                mac_op = '{valid: 1'b1, clr: 1'b0, sub: 1'b1, sh: '0};
                mul_a  = (state_reg == ST_F4) ? MUL_W'(a1_reg) : MUL_W'(a2_reg);
                mul_b  = MUL_W'(y_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_gain_reg   <= 24'd114688;
            drive_offset_reg <= '0;
            gate_amount_reg  <= 16'd19661;
            out_gain_reg     <= 20'd65536;
            bypass_reg       <= 1'b0;
            b0_reg           <= 24'sd368640;
            a1_reg           <= -24'sd5914624;
            a2_reg           <= 24'sd2097152;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fgl_pkg::CFG_DRIVE_GAIN:   drive_gain_reg   <= cfg_wr_data;
                fgl_pkg::CFG_DRIVE_OFFSET: drive_offset_reg <= cfg_wr_data;
                fgl_pkg::CFG_GATE_AMOUNT:  gate_amount_reg  <= cfg_wr_data[15:0];
                fgl_pkg::CFG_OUT_GAIN:     out_gain_reg     <= cfg_wr_data[19:0];
                fgl_pkg::CFG_BYPASS:       bypass_reg       <= cfg_wr_data[0];
                fgl_pkg::CFG_LOWPASS_B0:   b0_reg           <= cfg_wr_data;
                fgl_pkg::CFG_LOWPASS_A1:   a1_reg           <= cfg_wr_data;
                fgl_pkg::CFG_LOWPASS_A2:   a2_reg           <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                env_mem[i] <= '0;
                s1_mem[i]  <= '0;
                s2_mem[i]  <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_RES) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        chan_reg  <= s_channel_index;
                        idx_reg   <= in_idx;
                        x_reg     <= s_sample_in;
                        env_reg   <= env_mem[in_idx];
                        s1_reg    <= s1_mem[in_idx];
                        s2_reg    <= s2_mem[in_idx];
                        state_reg <= bypass_reg ? ST_BYP_MUL : ST_DRV_OFF;
                    end
                end
                ST_BYP_MUL:  state_reg <= ST_OUT_W;
                ST_DRV_OFF:  state_reg <= ST_DRV_MUL;
                ST_DRV_MUL:  state_reg <= ST_DRV_W;
                ST_DRV_W:    state_reg <= ST_DRV_CAP;
                ST_DRV_CAP: begin
                    neg_reg   <= drv_t[ACC_W-1];
                    mag_reg   <= drv_t[ACC_W-1] ? 26'(-drv_t) : 26'(drv_t);
                    state_reg <= ST_SQ_MUL;
                end
                ST_SQ_MUL:   state_reg <= ST_SQ_W;
                ST_SQ_W:     state_reg <= ST_SQ_CAP;
                ST_SQ_CAP: begin
                    u_reg     <= sq_u;
                    n1_reg    <= N1_BASE + 25'(sq_u);
                    d1_reg    <= (28'(sq_u) << 5) - (28'(sq_u) << 2) + D1_BASE;
                    state_reg <= ST_N1_MUL;
                end
                ST_N1_MUL:   state_reg <= ST_N1_W;
                ST_N1_W:     state_reg <= ST_N1_CAP;
                ST_N1_CAP: begin
                    n2_reg    <= 31'(acc >>> 16) + N2_BASE;
                    state_reg <= ST_N2_MUL;
                end
                ST_N2_MUL:   state_reg <= ST_N2_W;
                ST_N2_W:     state_reg <= ST_N2_CAP;
                ST_N2_CAP: begin
                    n3_reg    <= 36'(acc >>> 16) + N3_BASE;
                    state_reg <= ST_D1_MUL;
                end
                ST_D1_MUL:   state_reg <= ST_D1_W;
                ST_D1_W:     state_reg <= ST_D1_CAP;
                ST_D1_CAP: begin
                    d2_reg    <= 34'(acc >>> 16) + D2_BASE;
                    state_reg <= ST_D2_LO;
                end
                ST_D2_LO:    state_reg <= ST_D2_HI;
                ST_D2_HI:    state_reg <= ST_D2_W;
                ST_D2_W:     state_reg <= ST_D2_CAP;
                ST_D2_CAP: begin
                    d3_reg    <= 38'(acc >>> 16) + D3_BASE;
                    state_reg <= ST_NUM_LO;
                end
                ST_NUM_LO:   state_reg <= ST_NUM_HI;
                ST_NUM_HI:   state_reg <= ST_NUM_W;
                ST_NUM_W:    state_reg <= ST_NUM_DIV;
                ST_NUM_DIV:  state_reg <= ST_TANH_WAIT;
                ST_TANH_WAIT: begin
                    if (div_done) begin
                        lvl_reg   <= q_sat;
                        state_reg <= ST_THR_MUL;
                    end
                end
                ST_THR_MUL:  state_reg <= ST_THR_W;
                ST_THR_W:    state_reg <= ST_THR_CAP;
                ST_THR_CAP: begin
                    thr_reg   <= THR_BASE + 22'(acc >>> 16);
                    state_reg <= ST_ENV_A;
                end
                ST_ENV_A: begin
                    if (24'(lvl_reg) > env_reg) begin
                        env_reg          <= 24'(lvl_reg);
                        env_mem[idx_reg] <= 24'(lvl_reg);
                        state_reg        <= ST_GATE;
                    end else begin
                        state_reg <= ST_ENV_B;
                    end
                end
                ST_ENV_B:    state_reg <= ST_ENV_W;
                ST_ENV_W:    state_reg <= ST_ENV_CAP;
                ST_ENV_CAP: begin
                    env_reg          <= 24'(acc >>> 16);
                    env_mem[idx_reg] <= 24'(acc >>> 16);
                    state_reg        <= ST_GATE;
                end
                ST_GATE: begin
                    if (env_reg < 24'(thr_reg)) begin
                        state_reg <= ST_GATE_W;
                    end else begin
                        fg_reg    <= neg_reg ? -$signed({1'b0, lvl_reg})
                                             :  $signed({1'b0, lvl_reg});
                        state_reg <= ST_F0;
                    end
                end
                ST_GATE_W:   state_reg <= ST_GATE_DIV;
                ST_GATE_DIV: state_reg <= ST_GATE_WAIT;
                ST_GATE_WAIT: begin
                    if (div_done) begin
                        fg_reg    <= neg_reg ? -$signed({1'b0, gq}) : $signed({1'b0, gq});
                        state_reg <= ST_F0;
                    end
                end
                ST_F0:       state_reg <= ST_F1;
                ST_F1:       state_reg <= ST_F_W1;
                ST_F_W1:     state_reg <= ST_Y_CAP;
                ST_Y_CAP: begin
                    y_reg     <= sat32(acc >>> 22);
                    state_reg <= ST_F2;
                end
                ST_F2:       state_reg <= ST_F3;
                ST_F3:       state_reg <= ST_F4;
                ST_F4:       state_reg <= ST_F_W2;
                ST_F_W2:     state_reg <= ST_S1_CAP;
                ST_S1_CAP: begin
                    s1_mem[idx_reg] <= sat32(acc >>> 22);
                    state_reg       <= ST_F5;
                end
                ST_F5:       state_reg <= ST_F6;
                ST_F6:       state_reg <= ST_F_W3;
                ST_F_W3:     state_reg <= ST_S2_CAP;
                ST_S2_CAP: begin
                    s2_mem[idx_reg] <= sat32(acc >>> 22);
                    state_reg       <= ST_OUT_MUL;
                end
                ST_OUT_MUL:  state_reg <= ST_OUT_W;
                ST_OUT_W:    state_reg <= ST_RES;
                ST_RES: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_chan_reg   <= chan_reg;
                        m_sample_reg <= sat_smp(acc >>> 16);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
